// ===== hw/rtl/oas_pkg.sv =====
// Package for the obstacle avoidance steering pipeline.
// Holds command codes, register map, constants and the stage payload type.
`default_nettype none

package oas_pkg;

  localparam int unsigned DivStages = 5;
  localparam int unsigned DivBitsPerStage = 3;
  localparam int unsigned NumStages = DivStages + 4;

  localparam logic [15:0] InvalidCode = 16'd65535;
  localparam logic [15:0] BackupMs    = 16'd500;
  localparam logic [15:0] RotateMs    = 16'd800;
  localparam logic [15:0] FrontLimit  = 16'd300;
  localparam logic [7:0]  RotatePwm   = 8'd100;
  localparam logic [7:0]  BackFast    = 8'd150;
  localparam logic [7:0]  BackSlow    = 8'd100;
  localparam logic [16:0] CloseMargin = 17'd50;
  localparam logic signed [15:0] SteerMax  = 16'sd19661;
  localparam logic signed [15:0] SteerHalf = 16'sd16384;
  localparam logic signed [9:0]  SharpDrop = 10'sd30;
  localparam logic signed [9:0]  PwmTop    = 10'sd255;

  localparam logic [2:0] RegBoostTof  = 3'd0;
  localparam logic [2:0] RegBoostOpt  = 3'd1;
  localparam logic [2:0] RegBoostSpd  = 3'd2;
  localparam logic [2:0] RegBaseSpd   = 3'd3;
  localparam logic [2:0] RegCloseOpt  = 3'd4;
  localparam logic [2:0] RegCloseTof  = 3'd5;
  localparam logic [2:0] RegMaxCorr   = 3'd6;
  localparam logic [2:0] RegWeightRng = 3'd7;

  typedef enum logic [2:0] {
    CMD_RELEASE = 3'd0,
    CMD_FORWARD = 3'd1,
    CMD_BACKUP  = 3'd2,
    CMD_ROTATE  = 3'd3,
    CMD_NONE    = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [15:0] boost_tof;
    logic [15:0] boost_opt;
    logic [7:0]  pwm_fast;
    logic [7:0]  pwm_slow;
    logic [15:0] close_opt;
    logic [15:0] close_tof;
    logic [7:0]  max_corr;
    logic [15:0] weight_range;
  } cfg_t;

  typedef struct packed {
    cmd_e               kind;
    logic               opt_lt;
    logic               opt_gt;
    logic [7:0]         speed;
    logic               prio;
    logic signed [15:0] prio_s;
    logic signed [15:0] bias;
    logic [15:0]        rem_l;
    logic [15:0]        rem_r;
    logic [14:0]        quo_l;
    logic [14:0]        quo_r;
    logic signed [15:0] steer;
    logic               sharp;
    logic signed [24:0] prod;
    logic [7:0]         pwm_l;
    logic [7:0]         pwm_r;
  } item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/oas_decode.sv =====
// Front decode: classifies an item, picks speed and priority steer, forms remainders.
// Depends on oas_pkg.
`default_nettype none

module oas_decode import oas_pkg::*; (
  input  var cfg_t        cfg_i,
  input  wire  [15:0]     tof_left_i,
  input  wire  [15:0]     tof_right_i,
  input  wire  [15:0]     opt_left_i,
  input  wire  [15:0]     opt_right_i,
  input  wire  [15:0]     front_dist_i,
  input  wire  [15:0]     manual_bias_i,
  output item_t           item_o
);

  logic ol_inv, or_inv, fr_inv, straight;
  logic [16:0] opt_far, tof_far;

  always_comb begin
    ol_inv   = (opt_left_i == InvalidCode);
    or_inv   = (opt_right_i == InvalidCode);
    fr_inv   = (front_dist_i == InvalidCode);
    opt_far  = {1'b0, cfg_i.close_opt} + CloseMargin;
    tof_far  = {1'b0, cfg_i.close_tof} + CloseMargin;
    straight = (tof_left_i > cfg_i.boost_tof) && (tof_right_i > cfg_i.boost_tof) &&
               (opt_left_i > cfg_i.boost_opt) && (opt_right_i > cfg_i.boost_opt);

    item_o        = '0;
    item_o.opt_lt = (opt_left_i < opt_right_i);
    item_o.opt_gt = (opt_left_i > opt_right_i);
    item_o.bias   = $signed(manual_bias_i);
    item_o.speed  = straight ? cfg_i.pwm_fast : cfg_i.pwm_slow;

    if (fr_inv && ol_inv && or_inv) begin
      item_o.kind = CMD_RELEASE;
    end else if (!fr_inv && (front_dist_i < FrontLimit)) begin
      item_o.kind = (!ol_inv && !or_inv) ? CMD_BACKUP : CMD_NONE;
    end else begin
      item_o.kind = CMD_FORWARD;
    end

    item_o.prio = 1'b1;
    if ((opt_left_i < cfg_i.close_opt) && ({1'b0, opt_right_i} > opt_far)) begin
      item_o.prio_s = -SteerMax;
    end else if ((opt_right_i < cfg_i.close_opt) && ({1'b0, opt_left_i} > opt_far)) begin
      item_o.prio_s = SteerMax;
    end else if ((tof_left_i != 16'd0) && (tof_left_i < cfg_i.close_tof) &&
                 ({1'b0, tof_right_i} > tof_far)) begin
      item_o.prio_s = -SteerHalf;
    end else if ((tof_right_i != 16'd0) && (tof_right_i < cfg_i.close_tof) &&
                 ({1'b0, tof_left_i} > tof_far)) begin
      item_o.prio_s = SteerHalf;
    end else begin
      item_o.prio   = 1'b0;
      item_o.prio_s = '0;
    end

    if ((opt_left_i == 16'd0) || (opt_left_i > cfg_i.weight_range)) begin
      item_o.rem_l = '0;
    end else begin
      item_o.rem_l = cfg_i.weight_range - opt_left_i;
    end
    if ((opt_right_i == 16'd0) || (opt_right_i > cfg_i.weight_range)) begin
      item_o.rem_r = '0;
    end else begin
      item_o.rem_r = cfg_i.weight_range - opt_right_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/oas_div_step.sv =====
// Restoring division slice: DivBitsPerStage (3) quotient bits of remainder*32768/divisor.
// Depends on oas_pkg.
`default_nettype none

module oas_div_step import oas_pkg::*; (
  input  wire  [15:0] divisor_i,
  input  wire  [15:0] rem_i,
  input  wire  [14:0] quo_i,
  output logic [15:0] rem_o,
  output logic [14:0] quo_o
);

  logic [16:0] dbl;
  logic [15:0] rem;
  logic [14:0] quo;

  always_comb begin
    rem = rem_i;
    quo = quo_i;
    dbl = '0;
    for (int i = 0; i < DivBitsPerStage; i++) begin
      dbl = {rem, 1'b0};
      if ((divisor_i != 16'd0) && (dbl >= {1'b0, divisor_i})) begin
        rem = 16'(dbl - {1'b0, divisor_i});
        quo = {quo[13:0], 1'b1};
      end else begin
        rem = dbl[15:0];
        quo = {quo[13:0], 1'b0};
      end
    end
    rem_o = rem;
    quo_o = quo;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/oas_steer.sv =====
// Steer strength: priority value or weight difference plus bias, clamped.
// Depends on oas_pkg.
`default_nettype none

module oas_steer import oas_pkg::*; (
  input  var item_t item_i,
  output item_t     item_o
);

  logic signed [17:0] sum;

  always_comb begin
    item_o = item_i;
    if (item_i.prio) begin
      sum = 18'(item_i.prio_s);
    end else begin
      sum = $signed({3'b000, item_i.quo_r}) - $signed({3'b000, item_i.quo_l}) +
            18'(item_i.bias);
    end
    if (sum > 18'(SteerMax)) begin
      item_o.steer = SteerMax;
    end else if (sum < -18'(SteerMax)) begin
      item_o.steer = -SteerMax;
    end else begin
      item_o.steer = 16'(sum);
    end
    item_o.sharp = (item_o.steer > SteerHalf) || (item_o.steer < -SteerHalf);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/obstacle_avoid_steering.sv =====
// Obstacle avoidance steering: nine-stage pipeline, one item per cycle when the
// output is not stalled and no item gives two results. The weight divider
// (5 stages of 3 quotient bits) sets the depth. Items that give two results
// hold the output stage until both are taken. Reset is asynchronous, active low,
// clears valid bits and loads register defaults; there is no clearing pass.
`default_nettype none

module obstacle_avoid_steering import oas_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // tof_left, tof_right, opt_left, opt_right, front_dist, manual_bias
  input  wire  [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // pwm_left, pwm_right, left_forward, right_forward, hold_ms, zero pad
  output logic [39:0] m_axis_tdata,
  // command
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  cfg_t  cfg_q;
  item_t st_q [NumStages];
  item_t nx [NumStages];
  logic [NumStages-1:0] v_q, rdy;
  logic phase_q, two, drain;
  logic signed [9:0] corr, spd, pl, pr;
  item_t dec, str;
  logic [15:0] rl [DivStages];
  logic [15:0] rr [DivStages];
  logic [14:0] ql [DivStages];
  logic [14:0] qr [DivStages];

  assign pready = 1'b1;

  always_comb begin
    case (paddr[4:2])
      RegBoostTof:  prdata = {16'd0, cfg_q.boost_tof};
      RegBoostOpt:  prdata = {16'd0, cfg_q.boost_opt};
      RegBoostSpd:  prdata = {24'd0, cfg_q.pwm_fast};
      RegBaseSpd:   prdata = {24'd0, cfg_q.pwm_slow};
      RegCloseOpt:  prdata = {16'd0, cfg_q.close_opt};
      RegCloseTof:  prdata = {16'd0, cfg_q.close_tof};
      RegMaxCorr:   prdata = {24'd0, cfg_q.max_corr};
      RegWeightRng: prdata = {16'd0, cfg_q.weight_range};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.boost_tof    <= 16'd600;
      cfg_q.boost_opt    <= 16'd600;
      cfg_q.pwm_fast     <= 8'd200;
      cfg_q.pwm_slow     <= 8'd150;
      cfg_q.close_opt    <= 16'd200;
      cfg_q.close_tof    <= 16'd200;
      cfg_q.max_corr     <= 8'd100;
      cfg_q.weight_range <= 16'd1000;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        RegBoostTof:  cfg_q.boost_tof    <= pwdata[15:0];
        RegBoostOpt:  cfg_q.boost_opt    <= pwdata[15:0];
        RegBoostSpd:  cfg_q.pwm_fast     <= pwdata[7:0];
        RegBaseSpd:   cfg_q.pwm_slow     <= pwdata[7:0];
        RegCloseOpt:  cfg_q.close_opt    <= pwdata[15:0];
        RegCloseTof:  cfg_q.close_tof    <= pwdata[15:0];
        RegMaxCorr:   cfg_q.max_corr     <= pwdata[7:0];
        RegWeightRng: cfg_q.weight_range <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  oas_decode u_decode (
    .cfg_i         (cfg_q),
    .tof_left_i    (s_axis_tdata[15:0]),
    .tof_right_i   (s_axis_tdata[31:16]),
    .opt_left_i    (s_axis_tdata[47:32]),
    .opt_right_i   (s_axis_tdata[63:48]),
    .front_dist_i  (s_axis_tdata[79:64]),
    .manual_bias_i (s_axis_tdata[95:80]),
    .item_o        (dec)
  );

  for (genvar k = 0; k < DivStages; k++) begin : g_div
    oas_div_step u_div_l (
      .divisor_i (cfg_q.weight_range),
      .rem_i     (st_q[k].rem_l),
      .quo_i     (st_q[k].quo_l),
      .rem_o     (rl[k]),
      .quo_o     (ql[k])
    );
    oas_div_step u_div_r (
      .divisor_i (cfg_q.weight_range),
      .rem_i     (st_q[k].rem_r),
      .quo_i     (st_q[k].quo_r),
      .rem_o     (rr[k]),
      .quo_o     (qr[k])
    );
  end

  oas_steer u_steer (
    .item_i (st_q[DivStages]),
    .item_o (str)
  );

  always_comb begin
    nx[0] = dec;
    for (int k = 0; k < DivStages; k++) begin
      nx[k+1]       = st_q[k];
      nx[k+1].rem_l = rl[k];
      nx[k+1].quo_l = ql[k];
      nx[k+1].rem_r = rr[k];
      nx[k+1].quo_r = qr[k];
    end
    nx[DivStages+1]      = str;
    nx[DivStages+2]      = st_q[DivStages+1];
    nx[DivStages+2].prod = 25'(st_q[DivStages+1].steer) *
                           $signed({17'd0, cfg_q.max_corr});
    nx[DivStages+3] = st_q[DivStages+2];
    if (st_q[DivStages+2].prod < 0) begin
      corr = 10'((st_q[DivStages+2].prod + 25'sd32767) >>> 15);
    end else begin
      corr = 10'(st_q[DivStages+2].prod >>> 15);
    end
    spd = $signed({2'b00, st_q[DivStages+2].speed}) -
          (st_q[DivStages+2].sharp ? SharpDrop : 10'sd0);
    pl = spd - corr;
    pr = spd + corr;
    nx[DivStages+3].pwm_l = (pl < 0) ? 8'd0 : (pl > PwmTop) ? 8'd255 : pl[7:0];
    nx[DivStages+3].pwm_r = (pr < 0) ? 8'd0 : (pr > PwmTop) ? 8'd255 : pr[7:0];
  end

  assign two   = (st_q[NumStages-1].kind == CMD_BACKUP);
  assign drain = m_axis_tready && (!two || phase_q);

  always_comb begin
    rdy[NumStages-1] = !v_q[NumStages-1] || drain;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      phase_q <= 1'b0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
      if (rdy[NumStages-1]) begin
        phase_q <= 1'b0;
      end else if (v_q[NumStages-1] && m_axis_tready && two) begin
        phase_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumStages; k++) begin
      if (rdy[k]) begin
        st_q[k] <= nx[k];
      end
    end
  end

  always_comb begin
    m_axis_tvalid = v_q[NumStages-1];
    m_axis_tdata  = '0;
    m_axis_tuser  = st_q[NumStages-1].kind;
    m_axis_tlast  = 1'b1;
    case (st_q[NumStages-1].kind)
      CMD_FORWARD: begin
        m_axis_tdata[7:0]  = st_q[NumStages-1].pwm_l;
        m_axis_tdata[15:8] = st_q[NumStages-1].pwm_r;
        m_axis_tdata[16]   = 1'b1;
        m_axis_tdata[17]   = 1'b1;
      end
      CMD_BACKUP: begin
        if (phase_q) begin
          m_axis_tuser        = CMD_ROTATE;
          m_axis_tdata[7:0]   = RotatePwm;
          m_axis_tdata[15:8]  = RotatePwm;
          m_axis_tdata[16]    = !st_q[NumStages-1].opt_gt;
          m_axis_tdata[17]    = st_q[NumStages-1].opt_gt;
          m_axis_tdata[33:18] = RotateMs;
        end else begin
          m_axis_tlast        = 1'b0;
          m_axis_tdata[7:0]   = st_q[NumStages-1].opt_lt ? BackFast : BackSlow;
          m_axis_tdata[15:8]  = st_q[NumStages-1].opt_lt ? BackSlow : BackFast;
          m_axis_tdata[33:18] = BackupMs;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_two_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == CMD_BACKUP)
    else $error("non-final result that is not a back-up");
  a_rotate_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == CMD_ROTATE |-> m_axis_tlast)
    else $error("rotate result not final");
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for obstacle_avoid_steering: drives sensor items on the input stream
// and predicts the motor commands they cause. Results are checked against that prediction.
// Depends on oas_pkg and the obstacle_avoid_steering RTL.
`default_nettype none

module testbench;
  import oas_pkg::*;

  typedef struct {
    cmd_e        cmd;
    logic [7:0]  pwm_l;
    logic [7:0]  pwm_r;
    logic        fwd_l;
    logic        fwd_r;
    logic [15:0] hold;
    logic        last;
  } motor_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  wire [31:0] prdata;
  wire pready;
  logic s_axis_tvalid = 1'b0;
  wire s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  wire m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  wire [39:0] m_axis_tdata;
  wire [2:0] m_axis_tuser;
  wire m_axis_tlast;

  obstacle_avoid_steering u_dut (.*);

  always #2 clk_i = ~clk_i;

  cfg_t cfg;
  motor_cmd_t cmd_q[$];
  int errors = 0;
  int cycles = 0;
  bit idle_en = 1'b1;
  int hold_off = 0;
  int rx_idle = 0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  function automatic int weight(input int unsigned d);
    if (d == 0 || d > cfg.weight_range) return 0;
    return ((cfg.weight_range - d) * 32768) / cfg.weight_range;
  endfunction

  function automatic int clampi(input int v, input int lo, input int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic predict_steering(input logic [15:0] tl, tr, ol, orr, fr,
                                  input logic signed [15:0] bias);
    motor_cmd_t c;
    int speed, s, corr;
    bit straight;
    c = '{CMD_NONE, 0, 0, 0, 0, 0, 1};
    if (fr == InvalidCode && ol == InvalidCode && orr == InvalidCode) begin
      c.cmd = CMD_RELEASE;
      cmd_q.push_back(c);
      return;
    end
    if (fr != InvalidCode && fr < FrontLimit) begin
      if (ol != InvalidCode && orr != InvalidCode) begin
        c = '{CMD_BACKUP, (ol < orr) ? BackFast : BackSlow,
              (ol < orr) ? BackSlow : BackFast, 0, 0, BackupMs, 0};
        cmd_q.push_back(c);
        c = '{CMD_ROTATE, RotatePwm, RotatePwm, !(ol > orr), (ol > orr), RotateMs, 1};
      end
      cmd_q.push_back(c);
      return;
    end
    straight = tl > cfg.boost_tof && tr > cfg.boost_tof &&
               ol > cfg.boost_opt && orr > cfg.boost_opt;
    speed = straight ? cfg.pwm_fast : cfg.pwm_slow;
    if (ol < cfg.close_opt && orr > cfg.close_opt + 50) s = -19661;
    else if (orr < cfg.close_opt && ol > cfg.close_opt + 50) s = 19661;
    else if (tl > 0 && tl < cfg.close_tof && tr > cfg.close_tof + 50) s = -16384;
    else if (tr > 0 && tr < cfg.close_tof && tl > cfg.close_tof + 50) s = 16384;
    else s = weight(orr) - weight(ol) + int'(bias);
    s = clampi(s, -19661, 19661);
    corr = (s * int'(cfg.max_corr)) / 32768;
    if (s > 16384 || s < -16384) speed -= 30;
    c = '{CMD_FORWARD, 8'(clampi(speed - corr, 0, 255)), 8'(clampi(speed + corr, 0, 255)),
          1, 1, 0, 1};
    cmd_q.push_back(c);
  endtask

  task automatic send_readings(input logic [15:0] tl, tr, ol, orr, fr, bias);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {bias, fr, orr, ol, tr, tl};
    predict_steering(tl, tr, ol, orr, fr, bias);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegBoostTof:  cfg.boost_tof = val[15:0];
      RegBoostOpt:  cfg.boost_opt = val[15:0];
      RegBoostSpd:  cfg.pwm_fast = val[7:0];
      RegBaseSpd:   cfg.pwm_slow = val[7:0];
      RegCloseOpt:  cfg.close_opt = val[15:0];
      RegCloseTof:  cfg.close_tof = val[15:0];
      RegMaxCorr:   cfg.max_corr = val[7:0];
      RegWeightRng: cfg.weight_range = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (cmd_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_dist();
    case ($urandom_range(0, 5))
      0: return InvalidCode;
      1: return 16'($urandom_range(0, 300));
      2: return 16'($urandom_range(150, 260));
      3: return 16'($urandom);
      default: return 16'($urandom_range(0, 1200));
    endcase
  endfunction

  task automatic send_random(input int n);
    repeat (n) send_readings(rand_dist(), rand_dist(), rand_dist(), rand_dist(),
                             ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 299))
                                                          : rand_dist(), 16'($urandom));
  endtask

  task automatic test_directed();
    send_readings(0, 0, InvalidCode, InvalidCode, InvalidCode, 0);
    send_readings(700, 700, 100, 500, 100, 0);
    send_readings(700, 700, 500, 100, 100, 0);
    send_readings(700, 700, 300, 300, 0, 0);
    send_readings(700, 700, InvalidCode, 300, 200, 0);
    send_readings(700, 700, 700, 700, 299, 0);
    send_readings(700, 700, 700, 700, 300, 0);
    send_readings(700, 700, 100, 700, 1000, 0);
    send_readings(700, 700, 700, 100, 1000, 0);
    send_readings(100, 700, 400, 400, 1000, 0);
    send_readings(700, 100, 400, 400, 1000, 0);
    send_readings(400, 400, 0, 999, 1000, 16'h7fff);
    send_readings(400, 400, 999, 0, 1000, 16'h8000);
    send_readings(400, 400, 400, 400, 1000, 16'h5000);
    send_readings(16'hffff, 16'hffff, InvalidCode, InvalidCode, 1000, 16'hffff);
    send_readings(0, 0, 0, 0, 16'hfffe, 0);
    drain();
  endtask

  task automatic test_register_sweep();
    write_reg(RegBoostTof, 0); write_reg(RegBoostOpt, 16'hffff);
    write_reg(RegBoostSpd, 255); write_reg(RegBaseSpd, 0);
    write_reg(RegCloseOpt, 0); write_reg(RegCloseTof, 16'hffff);
    write_reg(RegMaxCorr, 255); write_reg(RegWeightRng, 1);
    send_random(300); drain();
    write_reg(RegBoostTof, 16'hffff); write_reg(RegBoostOpt, 0);
    write_reg(RegBoostSpd, 0); write_reg(RegBaseSpd, 255);
    write_reg(RegCloseOpt, 16'hffff); write_reg(RegCloseTof, 0);
    write_reg(RegMaxCorr, 0); write_reg(RegWeightRng, 16'hffff);
    send_random(300); drain();
    write_reg(RegBoostTof, 600); write_reg(RegBoostOpt, 600);
    write_reg(RegBoostSpd, 200); write_reg(RegBaseSpd, 20);
    write_reg(RegCloseOpt, 200); write_reg(RegCloseTof, 200);
    write_reg(RegMaxCorr, 255); write_reg(RegWeightRng, 1000);
    send_random(400); drain();
  endtask

  task automatic test_backpressure();
    hold_off = 200;
    send_random(100); drain();
  endtask

  task automatic test_random_default();
    write_reg(RegBaseSpd, 150); write_reg(RegMaxCorr, 100);
    send_random(400);
    idle_en = 1'b0;
    send_random(300); drain();
  endtask

  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      m_axis_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (rx_idle > 1) begin
      m_axis_tready <= 1'b0;
      rx_idle <= rx_idle - 1;
    end else if (rx_idle == 1) begin
      m_axis_tready <= 1'b1;
      rx_idle <= 0;
    end else if (idle_en && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      rx_idle <= $urandom_range(1, 3);
    end else
      m_axis_tready <= 1'b1;
  end

  always @(posedge clk_i) begin
    motor_cmd_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cmd_q.size() == 0) report("unexpected item", 0, 0);
      else begin
        w = cmd_q.pop_front();
        if (m_axis_tuser != w.cmd) report("command", m_axis_tuser, w.cmd);
        if (m_axis_tdata[7:0] != w.pwm_l) report("pwm_left", m_axis_tdata[7:0], w.pwm_l);
        if (m_axis_tdata[15:8] != w.pwm_r) report("pwm_right", m_axis_tdata[15:8], w.pwm_r);
        if (m_axis_tdata[16] != w.fwd_l) report("left_forward", m_axis_tdata[16], w.fwd_l);
        if (m_axis_tdata[17] != w.fwd_r) report("right_forward", m_axis_tdata[17], w.fwd_r);
        if (m_axis_tdata[33:18] != w.hold) report("hold_ms", m_axis_tdata[33:18], w.hold);
        if (m_axis_tlast != w.last) report("last", m_axis_tlast, w.last);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == 400000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    cfg = '{600, 600, 200, 150, 200, 200, 100, 1000};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_sweep();
    test_backpressure();
    test_random_default();
    if (errors == 0 && cmd_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

`default_nettype wire
